>>> hdl/crrm_pkg.sv
// Shared types and constants for the chained range remap block.
package crrm_pkg;

	localparam int STAGES_DEF     = 7;
	localparam int ENTRIES_DEF    = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int REQ_W         = 2;
	localparam int STAGE_IDX_W   = 3;
	localparam int ENTRY_IDX_W   = 5;
	localparam int STAGES_USE_W  = 3;
	localparam int CELL_IDX_W    = 4;
	localparam int ENTRY_CMP_W   = 9;

	localparam logic [STAGES_USE_W-1:0] STAGES_IN_USE_RST = 3'd7;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE  = 2'd0,
		REQ_XLATE  = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_IGNORE = 2'd3
	} req_t;

	// Control part of a transaction as it moves down the chain.
	typedef struct packed {
		logic                   valid;
		req_t                   kind;
		logic [STAGE_IDX_W-1:0] stage_index;
		logic [ENTRY_IDX_W-1:0] entry_index;
		logic                   entry_enable;
	} xfer_ctl_t;

endpackage

>>> hdl/crrm_cell.sv
// One translation stage: its range table, a parallel match and a registered add.
module crrm_cell #(
	parameter int CELL_INDEX = 0,
	parameter int ENTRIES    = crrm_pkg::ENTRIES_DEF,
	parameter int VALUE_BITS = crrm_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [crrm_pkg::STAGES_USE_W-1:0]   stages_in_use,
	input  crrm_pkg::xfer_ctl_t                 ctl_in,
	input  logic [VALUE_BITS-1:0]               wdest_in,
	input  logic [VALUE_BITS-1:0]               wsrc_in,
	input  logic [VALUE_BITS-1:0]               wspan_in,
	input  logic [VALUE_BITS-1:0]               val_in,
	input  logic                                ovf_in,
	output crrm_pkg::xfer_ctl_t                 ctl_out,
	output logic [VALUE_BITS-1:0]               wdest_out,
	output logic [VALUE_BITS-1:0]               wsrc_out,
	output logic [VALUE_BITS-1:0]               wspan_out,
	output logic [VALUE_BITS-1:0]               val_out,
	output logic                                ovf_out
);

	localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [VALUE_BITS-1:0] dest_q  [ENTRIES];
	logic [VALUE_BITS-1:0] src_q   [ENTRIES];
	logic [VALUE_BITS-1:0] span_q  [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	logic [VALUE_BITS:0]   diff [ENTRIES];
	logic [ENTRIES-1:0]    hit;
	logic                  hit_any;
	logic [VALUE_BITS-1:0] sel_dest;
	logic [VALUE_BITS-1:0] sel_diff;
	logic                  active;
	logic                  wr_en;
	logic [EIW-1:0]        wr_addr;

	crrm_pkg::xfer_ctl_t   ctl_s1;
	logic [VALUE_BITS-1:0] wdest_s1, wsrc_s1, wspan_s1, val_s1;
	logic                  ovf_s1, hit_s1;
	logic [VALUE_BITS-1:0] dest_s1, diff_s1;

	crrm_pkg::xfer_ctl_t   ctl_s2;
	logic [VALUE_BITS-1:0] wdest_s2, wsrc_s2, wspan_s2, val_s2;
	logic                  ovf_s2;
	logic [VALUE_BITS:0]   sum;

	assign active = ctl_in.valid && (ctl_in.kind == crrm_pkg::REQ_XLATE) &&
		(crrm_pkg::CELL_IDX_W'(CELL_INDEX) < {1'b0, stages_in_use});

	assign wr_en = advance && ctl_in.valid && (ctl_in.kind == crrm_pkg::REQ_WRITE) &&
		({1'b0, ctl_in.stage_index} == crrm_pkg::CELL_IDX_W'(CELL_INDEX)) &&
		({4'b0, ctl_in.entry_index} < crrm_pkg::ENTRY_CMP_W'(ENTRIES));
	assign wr_addr = EIW'(ctl_in.entry_index);

	// Every entry tests the value against its source range at once.
	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			diff[e] = {1'b0, val_in} - {1'b0, src_q[e]};
			hit[e]  = active && valid_q[e] && !diff[e][VALUE_BITS] &&
				(diff[e][VALUE_BITS-1:0] < span_q[e]);
		end
	end

	// Lowest-numbered matching entry wins.
	always_comb begin
		hit_any  = 1'b0;
		sel_dest = '0;
		sel_diff = '0;
		for (int e = ENTRIES - 1; e >= 0; e--) begin
			if (hit[e]) begin
				hit_any  = 1'b1;
				sel_dest = dest_q[e];
				sel_diff = diff[e][VALUE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= ctl_in.entry_enable;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dest_q[wr_addr] <= wdest_in;
			src_q[wr_addr]  <= wsrc_in;
			span_q[wr_addr] <= wspan_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	assign sum = {1'b0, dest_s1} + {1'b0, diff_s1};

	always_ff @(posedge clk) begin
		if (advance) begin
			wdest_s1 <= wdest_in;
			wsrc_s1  <= wsrc_in;
			wspan_s1 <= wspan_in;
			val_s1   <= val_in;
			ovf_s1   <= ovf_in;
			hit_s1   <= hit_any;
			dest_s1  <= sel_dest;
			diff_s1  <= sel_diff;

			wdest_s2 <= wdest_s1;
			wsrc_s2  <= wsrc_s1;
			wspan_s2 <= wspan_s1;
			val_s2   <= hit_s1 ? sum[VALUE_BITS-1:0] : val_s1;
			ovf_s2   <= ovf_s1 | (hit_s1 & sum[VALUE_BITS]);
		end
	end

	assign ctl_out   = ctl_s2;
	assign wdest_out = wdest_s2;
	assign wsrc_out  = wsrc_s2;
	assign wspan_out = wspan_s2;
	assign val_out   = val_s2;
	assign ovf_out   = ovf_s2;

endmodule

>>> hdl/crrm_min.sv
// Running minimum tracker and output register at the end of the chain.
module crrm_min #(
	parameter int VALUE_BITS = crrm_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  crrm_pkg::xfer_ctl_t   ctl_in,
	input  logic [VALUE_BITS-1:0] val_in,
	input  logic                  ovf_in,
	output logic                  res_valid,
	output logic [VALUE_BITS-1:0] res_value,
	output logic [VALUE_BITS-1:0] res_min,
	output logic                  res_ovf
);

	logic [VALUE_BITS-1:0] min_q;
	logic                  seen_q;
	logic                  valid_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] min_out_q;
	logic                  ovf_q;
	logic                  is_xlate;
	logic                  is_clear;
	logic [VALUE_BITS-1:0] next_min;

	assign is_xlate = ctl_in.valid && (ctl_in.kind == crrm_pkg::REQ_XLATE);
	assign is_clear = ctl_in.valid && (ctl_in.kind == crrm_pkg::REQ_CLEAR);
	assign next_min = (!seen_q || (val_in < min_q)) ? val_in : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '1;
			seen_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= is_xlate;
			if (is_clear) begin
				min_q  <= '1;
				seen_q <= 1'b0;
			end else if (is_xlate) begin
				min_q  <= next_min;
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_xlate) begin
			value_q   <= val_in;
			min_out_q <= next_min;
			ovf_q     <= ovf_in;
		end
	end

	assign res_valid = valid_q;
	assign res_value = value_q;
	assign res_min   = min_out_q;
	assign res_ovf   = ovf_q;

endmodule

>>> hdl/chained_range_remap_with_minimum_core.sv
// A transaction passes both registers of every stage cell, then the output register.
// Each stage cell holds two registers and the output register adds one more stage.
// Throughput: one transaction per cycle; each stage cell matches all its entries in parallel.
// The whole chain advances together and holds while a result waits at the output.
// Reset clears all entry valid bits, sets the minimum to all ones and stages_in_use to 7.
// Table contents are not cleared; no clearing pass is needed.
module chained_range_remap_with_minimum_core #(
	parameter int STAGES     = crrm_pkg::STAGES_DEF,
	parameter int ENTRIES    = crrm_pkg::ENTRIES_DEF,
	parameter int VALUE_BITS = crrm_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crrm_pkg::STAGES_USE_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [crrm_pkg::REQ_W-1:0]          req_type,
	input  logic [crrm_pkg::STAGE_IDX_W-1:0]    stage_index,
	input  logic [crrm_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  logic [VALUE_BITS-1:0]               dest_start,
	input  logic [VALUE_BITS-1:0]               source_start,
	input  logic [VALUE_BITS-1:0]               span_length,
	input  logic                                entry_enable,
	input  logic [VALUE_BITS-1:0]               value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [VALUE_BITS-1:0]               mapped_value,
	output logic [VALUE_BITS-1:0]               running_min,
	output logic                                overflow
);

	logic [crrm_pkg::STAGES_USE_W-1:0] stages_in_use_q;
	logic                              advance;

	crrm_pkg::xfer_ctl_t   ctl   [STAGES+1];
	logic [VALUE_BITS-1:0] wdest [STAGES+1];
	logic [VALUE_BITS-1:0] wsrc  [STAGES+1];
	logic [VALUE_BITS-1:0] wspan [STAGES+1];
	logic [VALUE_BITS-1:0] val   [STAGES+1];
	logic                  ovf   [STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stages_in_use_q <= crrm_pkg::STAGES_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			stages_in_use_q <= cfg_data;
		end
	end

	// The chain moves only when the output register is free or being emptied.
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// Request type three is dropped here and never enters the chain.
	assign ctl[0].valid        = in_valid && (req_type != crrm_pkg::REQ_IGNORE);
	assign ctl[0].kind         = crrm_pkg::req_t'(req_type);
	assign ctl[0].stage_index  = stage_index;
	assign ctl[0].entry_index  = entry_index;
	assign ctl[0].entry_enable = entry_enable;
	assign wdest[0] = dest_start;
	assign wsrc[0]  = source_start;
	assign wspan[0] = span_length;
	assign val[0]   = value;
	assign ovf[0]   = 1'b0;

	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		crrm_cell #(
			.CELL_INDEX (g),
			.ENTRIES    (ENTRIES),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.stages_in_use (stages_in_use_q),
			.ctl_in        (ctl[g]),
			.wdest_in      (wdest[g]),
			.wsrc_in       (wsrc[g]),
			.wspan_in      (wspan[g]),
			.val_in        (val[g]),
			.ovf_in        (ovf[g]),
			.ctl_out       (ctl[g+1]),
			.wdest_out     (wdest[g+1]),
			.wsrc_out      (wsrc[g+1]),
			.wspan_out     (wspan[g+1]),
			.val_out       (val[g+1]),
			.ovf_out       (ovf[g+1])
		);
	end

	crrm_min #(
		.VALUE_BITS (VALUE_BITS)
	) u_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctl_in    (ctl[STAGES]),
		.val_in    (val[STAGES]),
		.ovf_in    (ovf[STAGES]),
		.res_valid (out_valid),
		.res_value (mapped_value),
		.res_min   (running_min),
		.res_ovf   (overflow)
	);

	// The reported minimum can never exceed the value reported with it.
	a_min_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running_min <= mapped_value))
		else $error("running minimum above mapped value");

	// With no stage applied, no sum is formed, so no wrap can be flagged.
	a_ovf_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (stages_in_use_q != '0))
		else $error("overflow flagged with no stages in use");

	// A held result keeps the whole chain frozen.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(ctl[STAGES]) && $stable(val[STAGES])))
		else $error("chain moved while result was stalled");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the chained range remap block with running minimum.
module tb_top;

	localparam int VW               = crrm_pkg::VALUE_BITS_DEF;
	localparam int LATENCY          = 2 * crrm_pkg::STAGES_DEF;
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int TIMEOUT_CYCLES   = 400000;

	typedef struct packed {
		crrm_pkg::req_t                   kind;
		logic [crrm_pkg::STAGE_IDX_W-1:0] stage;
		logic [crrm_pkg::ENTRY_IDX_W-1:0] slot;
		logic [VW-1:0]                    dest;
		logic [VW-1:0]                    src;
		logic [VW-1:0]                    span;
		logic                             enable;
		logic [VW-1:0]                    value;
	} remap_req_t;

	typedef struct packed {
		logic [VW-1:0] mapped;
		logic [VW-1:0] minimum;
		logic          ovf;
	} remap_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [crrm_pkg::STAGES_USE_W-1:0] cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [crrm_pkg::REQ_W-1:0]        req_type = '0;
	logic [crrm_pkg::STAGE_IDX_W-1:0]  stage_index = '0;
	logic [crrm_pkg::ENTRY_IDX_W-1:0]  entry_index = '0;
	logic [VW-1:0]                     dest_start = '0;
	logic [VW-1:0]                     source_start = '0;
	logic [VW-1:0]                     span_length = '0;
	logic                              entry_enable = 1'b0;
	logic [VW-1:0]                     value = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [VW-1:0]                     mapped_value;
	logic [VW-1:0]                     running_min;
	logic                              overflow;

	chained_range_remap_with_minimum_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.stage_index (stage_index),
		.entry_index (entry_index),
		.dest_start  (dest_start),
		.source_start(source_start),
		.span_length (span_length),
		.entry_enable(entry_enable),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mapped_value(mapped_value),
		.running_min (running_min),
		.overflow    (overflow)
	);

	// Local copy of the translation tables, the minimum tracker and the stage count.
	logic [VW-1:0] stage_dest [crrm_pkg::STAGES_DEF][crrm_pkg::ENTRIES_DEF];
	logic [VW-1:0] stage_src  [crrm_pkg::STAGES_DEF][crrm_pkg::ENTRIES_DEF];
	logic [VW-1:0] stage_span [crrm_pkg::STAGES_DEF][crrm_pkg::ENTRIES_DEF];
	logic          stage_live [crrm_pkg::STAGES_DEF][crrm_pkg::ENTRIES_DEF];
	logic [VW-1:0] min_so_far = '1;
	logic          min_seen = 1'b0;
	logic [crrm_pkg::STAGES_USE_W-1:0] active_stages = crrm_pkg::STAGES_IN_USE_RST;

	remap_req_t    pending_reqs[$];
	remap_result_t expected_results[$];
	remap_req_t    on_wire;
	int            queued_count = 0;
	int            accepted_count = 0;
	int            results_checked = 0;
	int            overflow_seen = 0;
	int            fail_count = 0;
	int            send_gap = 0;
	int            hold_left = 0;
	logic          idle_bursts = 1'b1;

	initial begin
		for (int s = 0; s < crrm_pkg::STAGES_DEF; s++)
			for (int e = 0; e < crrm_pkg::ENTRIES_DEF; e++)
				stage_live[s][e] = 1'b0;
	end

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * TIMEOUT_CYCLES);
		$display("tb_top: FAIL");
		$finish;
	end

	// Applies one accepted transaction to the local state and queues its result, if any.
	function automatic void remap_and_track_min(input remap_req_t r);
		logic [VW-1:0] v;
		logic [VW-1:0] offset;
		logic [VW:0]   sum;
		logic          ovf;
		logic          hit;
		int            n;
		remap_result_t res;
		case (r.kind)
			crrm_pkg::REQ_WRITE: begin
				if (r.stage < crrm_pkg::STAGES_DEF && r.slot < crrm_pkg::ENTRIES_DEF) begin
					stage_dest[r.stage][r.slot] = r.dest;
					stage_src[r.stage][r.slot]  = r.src;
					stage_span[r.stage][r.slot] = r.span;
					stage_live[r.stage][r.slot] = r.enable;
				end
			end
			crrm_pkg::REQ_CLEAR: begin
				min_so_far = '1;
				min_seen   = 1'b0;
			end
			crrm_pkg::REQ_XLATE: begin
				v   = r.value;
				ovf = 1'b0;
				n   = (active_stages > crrm_pkg::STAGES_DEF) ? crrm_pkg::STAGES_DEF :
					active_stages;
				for (int s = 0; s < n; s++) begin
					hit = 1'b0;
					for (int e = 0; e < crrm_pkg::ENTRIES_DEF && !hit; e++) begin
						if (stage_live[s][e] && v >= stage_src[s][e] &&
						    (v - stage_src[s][e]) < stage_span[s][e]) begin
							hit    = 1'b1;
							offset = v - stage_src[s][e];
							sum    = {1'b0, stage_dest[s][e]} + {1'b0, offset};
							if (sum[VW])
								ovf = 1'b1;
							v = sum[VW-1:0];
						end
					end
				end
				if (!min_seen || v < min_so_far) begin
					min_so_far = v;
					min_seen   = 1'b1;
				end
				res.mapped  = v;
				res.minimum = min_so_far;
				res.ovf     = ovf;
				expected_results.insert(expected_results.size(), res);
			end
			default: ;
		endcase
	endfunction

	function automatic remap_req_t mk_plain(input crrm_pkg::req_t kind);
		remap_req_t r;
		r.kind   = kind;
		r.stage  = crrm_pkg::STAGE_IDX_W'($urandom_range(0, 7));
		r.slot   = crrm_pkg::ENTRY_IDX_W'($urandom_range(0, 31));
		r.dest   = $urandom;
		r.src    = $urandom;
		r.span   = $urandom;
		r.enable = 1'($urandom_range(0, 1));
		r.value  = $urandom;
		return r;
	endfunction

	function automatic remap_req_t mk_write(input int st, input int sl, input logic [VW-1:0] d,
			input logic [VW-1:0] s, input logic [VW-1:0] l, input logic en);
		remap_req_t r;
		r        = mk_plain(crrm_pkg::REQ_WRITE);
		r.stage  = crrm_pkg::STAGE_IDX_W'(st);
		r.slot   = crrm_pkg::ENTRY_IDX_W'(sl);
		r.dest   = d;
		r.src    = s;
		r.span   = l;
		r.enable = en;
		return r;
	endfunction

	function automatic remap_req_t mk_xlate(input logic [VW-1:0] v);
		remap_req_t r;
		r       = mk_plain(crrm_pkg::REQ_XLATE);
		r.value = v;
		return r;
	endfunction

	// Mostly writes into a small value window plus translations that land in it, so values
	// chain through several stages; the rest is clears, wrapping entries and noise.
	function automatic remap_req_t random_req();
		remap_req_t r;
		int         pick;
		r       = mk_plain(crrm_pkg::REQ_XLATE);
		r.stage = crrm_pkg::STAGE_IDX_W'($urandom_range(0, crrm_pkg::STAGES_DEF - 1));
		pick    = $urandom_range(0, 99);
		if (pick < 18) begin
			r.kind   = crrm_pkg::REQ_WRITE;
			r.dest   = $urandom_range(0, 1023);
			r.src    = $urandom_range(0, 1023);
			r.span   = $urandom_range(0, 300);
			r.enable = ($urandom_range(0, 9) != 0);
		end else if (pick < 20) begin
			r.kind   = crrm_pkg::REQ_WRITE;
			r.dest   = 32'hFFFF_FF00 | $urandom_range(0, 255);
			r.src    = $urandom_range(0, 1023);
			r.span   = $urandom_range(1, 600);
			r.enable = 1'b1;
		end else if (pick < 23) begin
			r.kind = crrm_pkg::REQ_CLEAR;
		end else if (pick < 25) begin
			r = mk_plain(crrm_pkg::REQ_WRITE);
		end else if (pick < 27) begin
			r.kind = crrm_pkg::REQ_IGNORE;
		end else if (pick < 29) begin
			r.kind  = crrm_pkg::REQ_WRITE;
			r.stage = crrm_pkg::STAGE_IDX_W'(crrm_pkg::STAGES_DEF);
		end else if (pick < 92) begin
			r.value = $urandom_range(0, 1100);
		end
		return r;
	endfunction

	task automatic push_req(input remap_req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
		queued_count++;
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			push_req(random_req());
	endtask

	// Waits until every queued transaction is accepted and every result is back, then lets
	// writes and clears still in the chain drain out.
	task automatic drain();
		do
			@(posedge clk);
		while (accepted_count != queued_count || expected_results.size() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_stage_count(input logic [crrm_pkg::STAGES_USE_W-1:0] n);
		drain();
		cfg_data  <= n;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		active_stages = n;
		cfg_valid <= 1'b0;
	endtask

	// Input driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			req_type     <= '0;
			stage_index  <= '0;
			entry_index  <= '0;
			dest_start   <= '0;
			source_start <= '0;
			span_length  <= '0;
			entry_enable <= 1'b0;
			value        <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				remap_and_track_min(on_wire);
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					on_wire = pending_reqs.pop_front();
					in_valid     <= 1'b1;
					req_type     <= on_wire.kind;
					stage_index  <= on_wire.stage;
					entry_index  <= on_wire.slot;
					dest_start   <= on_wire.dest;
					source_start <= on_wire.src;
					span_length  <= on_wire.span;
					entry_enable <= on_wire.enable;
					value        <= on_wire.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		remap_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected: mapped_value %h", mapped_value);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (mapped_value !== want.mapped) begin
						$error("mapped_value: expected %h, actual %h", want.mapped, mapped_value);
						fail_count++;
					end
					if (running_min !== want.minimum) begin
						$error("running_min: expected %h, actual %h", want.minimum, running_min);
						fail_count++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow: expected %b, actual %b", want.ovf, overflow);
						fail_count++;
					end
				end
				if (overflow === 1'b1)
					overflow_seen++;
				results_checked++;
				// One long stall so the chain fills and pushes back on the input.
				if (results_checked == LONG_HOLD_AT)
					hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with all seven stages from reset.
		push_req(mk_xlate(32'hFFFF_FFFF));
		push_req(mk_xlate(32'h0));
		push_req(mk_plain(crrm_pkg::REQ_CLEAR));
		push_req(mk_write(0, 5, 1000, 100, 50, 1'b1));
		push_req(mk_write(0, 2, 5000, 120, 10, 1'b1));
		push_req(mk_write(0, 1, 7, 100, 0, 1'b1));
		push_req(mk_write(0, 0, 9, 100, 100, 1'b0));
		push_req(mk_xlate(100));
		push_req(mk_xlate(125));
		push_req(mk_xlate(149));
		push_req(mk_xlate(150));
		push_req(mk_write(1, 0, 32'hFFFF_FFF0, 1000, 100, 1'b1));
		push_req(mk_xlate(130));
		push_req(mk_plain(crrm_pkg::REQ_CLEAR));
		push_req(mk_write(6, 31, 0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1));
		push_req(mk_xlate(32'hFFFF_FFFF));
		push_req(mk_xlate(32'hFFFF_FEFF));
		push_req(mk_write(7, 0, 1, 0, 32'hFFFF_FFFF, 1'b1));
		push_req(mk_plain(crrm_pkg::REQ_IGNORE));
		push_req(mk_write(5, 31, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b1));
		push_req(mk_xlate(2));
		push_req(mk_write(5, 31, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0));
		push_req(mk_xlate(0));

		write_stage_count(1);
		queue_random(200);
		write_stage_count(0);
		queue_random(100);
		write_stage_count(7);
		queue_random(200);
		// The sender stops here until every outstanding result is back.
		drain();
		queue_random(200);
		write_stage_count(4);
		queue_random(300);
		write_stage_count(2);
		queue_random(150);
		write_stage_count(7);
		idle_bursts <= 1'b0;
		queue_random(230);
		drain();

		$display("Covered %0d input transactions and %0d checked results, %0d of them wrapped.",
			accepted_count, results_checked, overflow_seen);
		$display("Stage counts 7, 1, 0, 7, 4, 2, 7 were used, with back-pressure on both sides.");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> files.f
hdl/crrm_pkg.sv
hdl/crrm_cell.sv
hdl/crrm_min.sv
hdl/chained_range_remap_with_minimum_core.sv
tb/tb_top.sv
